@@ hw/rtl/i2cmbe_pkg.sv @@
package i2cmbe_pkg;

	// command codes as carried on s_tuser
	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_WRITE = 3'd3,
		CMD_READ  = 3'd4
	} cmd_t;

	// one classified tick
	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] tx_byte;
		logic       ack_level;
		logic       sda_in;
	} item_t;

	// one result beat
	typedef struct packed {
		logic       scl_level;
		logic       sda_drive;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_ok;
	} result_t;

	localparam int unsigned S_TDATA_W = 16;
	localparam int unsigned S_TUSER_W = 3;
	localparam int unsigned M_TDATA_W = 16;

	localparam logic [15:0] PHASE_TICKS_RESET = 16'd5;

	localparam logic [4:0] BUS_PHASES   = 5'd3;
	localparam logic [4:0] WRITE_PHASES = 5'd27;
	localparam logic [4:0] READ_PHASES  = 5'd21;

	// write: 24 data phases, then ack slot (sample in the middle one)
	localparam logic [4:0] WR_ACK_FIRST  = 5'd24;
	localparam logic [4:0] WR_ACK_SAMPLE = 5'd25;

	// read: release, 16 bit phases, then the master ack slot
	localparam logic [4:0] RD_LAST_BIT  = 5'd16;
	localparam logic [4:0] RD_ACK_LOW   = 5'd17;
	localparam logic [4:0] RD_ACK_DRIVE = 5'd18;
	localparam logic [4:0] RD_ACK_HIGH  = 5'd19;

	localparam logic [1:0] SLOT_LAST = 2'd2;

endpackage

@@ hw/rtl/i2cmbe_front.sv @@
module i2cmbe_front
	import i2cmbe_pkg::*;
(
	input  logic [S_TDATA_W-1:0] tdata,
	input  logic [S_TUSER_W-1:0] tuser,
	output item_t                item
);

	// undefined action codes behave as no command
	always_comb begin
		case (tuser) inside
			CMD_START, CMD_STOP, CMD_WRITE, CMD_READ: item.cmd = cmd_t'(tuser);
			default:                                  item.cmd = CMD_NONE;
		endcase
		item.tx_byte   = tdata[7:0];
		item.ack_level = tdata[8];
		item.sda_in    = tdata[9];
	end

endmodule

@@ hw/rtl/i2cmbe_queue.sv @@
module i2cmbe_queue
	import i2cmbe_pkg::*;
#(
	parameter int unsigned DEPTH = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output item_t pop_item
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	item_t             mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/i2cmbe_back.sv @@
module i2cmbe_back
	import i2cmbe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] phase_ticks,
	input  logic        in_valid,
	output logic        in_ready,
	input  item_t       item,
	output logic        out_valid,
	input  logic        out_ready,
	output result_t     result
);

	// sequencer state
	cmd_t       cmd_q;
	logic [4:0] phase_q;
	logic [15:0] tick_q;
	logic [7:0] shift_q;
	logic [7:0] rx_q;
	logic       ack_q;
	logic       scl_q;
	logic       oe_q;
	logic       sdo_q;
	logic [1:0] slot_q;
	logic [2:0] bit_q;

	logic       out_valid_q;
	result_t    result_q;

	// next-state
	logic       start;
	cmd_t       cmd;
	logic [4:0] phase;
	logic [15:0] tick;
	logic [7:0] shift;
	logic [1:0] slot;
	logic [2:0] bitn;
	logic       wbit;
	logic       samples;
	logic [15:0] len;
	logic       phase_end;
	logic [4:0] nphases;

	cmd_t       cmd_d;
	logic [4:0] phase_d;
	logic [15:0] tick_d;
	logic [7:0] shift_d;
	logic [7:0] rx_d;
	logic       ack_d;
	logic       scl_d;
	logic       oe_d;
	logic       sdo_d;
	logic [1:0] slot_d;
	logic [2:0] bit_d;
	logic       done;
	logic       step;

	assign in_ready  = !out_valid_q || out_ready;
	assign step      = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign result    = result_q;

	always_comb begin
		start = (cmd_q == CMD_NONE) && (item.cmd != CMD_NONE);
		cmd   = start ? item.cmd : cmd_q;
		phase = start ? 5'd0 : phase_q;
		tick  = start ? 16'd0 : tick_q;
		shift = start ? ((item.cmd == CMD_WRITE) ? item.tx_byte : 8'd0) : shift_q;
		slot  = start ? 2'd0 : slot_q;
		bitn  = start ? 3'd0 : bit_q;
		wbit  = shift[~bitn];

		scl_d   = scl_q;
		oe_d    = oe_q;
		sdo_d   = sdo_q;
		samples = 1'b0;

		// line levels of the current phase
		case (cmd)
			CMD_START: begin
				if (phase == 5'd0) begin
					scl_d = 1'b1;
					sdo_d = 1'b1;
				end else if (phase == 5'd1) begin
					sdo_d = 1'b0;
				end else begin
					scl_d = 1'b0;
				end
			end
			CMD_STOP: begin
				if (phase == 5'd0) begin
					scl_d = 1'b0;
					sdo_d = 1'b0;
				end else if (phase == 5'd1) begin
					scl_d = 1'b1;
				end else begin
					sdo_d = 1'b1;
				end
			end
			CMD_WRITE: begin
				if (phase < WR_ACK_FIRST) begin
					case (slot)
						2'd0: scl_d = 1'b0;
						2'd1: begin
							scl_d = 1'b0;
							sdo_d = wbit;
						end
						default: begin
							scl_d = 1'b1;
							sdo_d = wbit;
						end
					endcase
				end else begin
					oe_d    = 1'b0;
					scl_d   = (phase == WR_ACK_SAMPLE);
					samples = (phase == WR_ACK_SAMPLE);
				end
			end
			CMD_READ: begin
				if (phase == 5'd0) begin
					sdo_d = 1'b1;
					oe_d  = 1'b0;
				end else if (phase <= RD_LAST_BIT) begin
					// even phases are SCL high and sample
					scl_d   = ~phase[0];
					samples = ~phase[0];
				end else if (phase == RD_ACK_LOW) begin
					scl_d = 1'b0;
				end else if (phase == RD_ACK_DRIVE) begin
					oe_d  = 1'b1;
					sdo_d = item.ack_level;
				end else if (phase == RD_ACK_HIGH) begin
					scl_d = 1'b1;
				end else begin
					scl_d = 1'b0;
				end
			end
			default: ;
		endcase

		len       = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
		phase_end = ({1'b0, tick} + 17'd1) >= {1'b0, len};

		case (cmd)
			CMD_WRITE: nphases = WRITE_PHASES;
			CMD_READ:  nphases = READ_PHASES;
			default:   nphases = BUS_PHASES;
		endcase

		cmd_d   = cmd;
		phase_d = phase;
		tick_d  = tick;
		shift_d = shift;
		rx_d    = rx_q;
		ack_d   = ack_q;
		slot_d  = slot;
		bit_d   = bitn;
		done    = 1'b0;

		if (cmd != CMD_NONE) begin
			if (phase_end) begin
				if (samples) begin
					if (cmd == CMD_WRITE) begin
						ack_d = ~item.sda_in;
					end else begin
						shift_d = {shift[6:0], item.sda_in};
					end
				end
				tick_d  = 16'd0;
				phase_d = phase + 5'd1;
				if (slot == SLOT_LAST) begin
					slot_d = 2'd0;
					bit_d  = bitn + 3'd1;
				end else begin
					slot_d = slot + 2'd1;
				end
				if (phase_d >= nphases) begin
					if (cmd == CMD_WRITE) begin
						oe_d = 1'b1;
					end
					if (cmd == CMD_READ) begin
						rx_d = shift_d;
					end
					cmd_d   = CMD_NONE;
					phase_d = 5'd0;
					done    = 1'b1;
				end
			end else begin
				tick_d = tick + 16'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q       <= CMD_NONE;
			phase_q     <= '0;
			tick_q      <= '0;
			shift_q     <= '0;
			rx_q        <= '0;
			ack_q       <= 1'b0;
			scl_q       <= 1'b1;
			oe_q        <= 1'b1;
			sdo_q       <= 1'b1;
			slot_q      <= '0;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				cmd_q   <= cmd_d;
				phase_q <= phase_d;
				tick_q  <= tick_d;
				shift_q <= shift_d;
				rx_q    <= rx_d;
				ack_q   <= ack_d;
				scl_q   <= scl_d;
				oe_q    <= oe_d;
				sdo_q   <= sdo_d;
				slot_q  <= slot_d;
				bit_q   <= bit_d;
			end
			if (in_ready) begin
				out_valid_q <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q.scl_level <= scl_d;
			result_q.sda_drive <= oe_d;
			result_q.sda_level <= sdo_d;
			result_q.busy_res  <= (cmd_d != CMD_NONE);
			result_q.done_res  <= done;
			result_q.rx_byte   <= rx_d;
			result_q.ack_ok    <= ack_d;
		end
	end

endmodule

@@ hw/rtl/i2c_master_byte_engine_top.sv @@
// I2C master byte engine. Every beat on the slave stream is one bus tick:
// s_tuser carries the command (none, start, stop, write byte, read byte) and
// s_tdata the byte to send, the ack level to drive after a read and the
// sampled SDA level. Commands are taken only while idle; others are ignored.
// Each command runs a fixed list of phases (start/stop 3, write 27, read 21),
// each phase_ticks ticks long (0 acts as 1), so a command spans
// phases * phase_ticks beats. Every input beat yields exactly one output beat
// with the SCL level, SDA enable and level, busy, done, last read byte and
// last write ack. Throughput is one beat per clock unless m_tready stalls;
// each beat is registered in the command queue and again in the output
// register. The sequencer updates its state once per beat, setting the rate.
// phase_ticks is written through cfg_* and should only change while idle.
module i2c_master_byte_engine_top
	import i2cmbe_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,

	// config write: phase_ticks
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [15:0]          cfg_data,

	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // tx_byte[7:0], ack_level[8], sda_in[9], zero pad
	input  logic [S_TUSER_W-1:0] s_tuser,   // action[2:0]

	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata    // scl_level[0], sda_drive[1], sda_level[2],
	                                        // busy_res[3], done_res[4], rx_byte[12:5],
	                                        // ack_ok[13], zero pad
);

	logic [15:0] phase_ticks_q;
	item_t       front_item;
	item_t       q_item;
	logic        q_valid;
	logic        q_ready;
	result_t     res;

	// config register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RESET;
		end else if (cfg_valid) begin
			phase_ticks_q <= cfg_data;
		end
	end

	// front: unpack and classify the command
	i2cmbe_front u_front (
		.tdata (s_tdata),
		.tuser (s_tuser),
		.item  (front_item)
	);

	// short queue decouples intake from the sequencer
	i2cmbe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (s_tvalid),
		.push_ready (s_tready),
		.push_item  (front_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_item   (q_item)
	);

	// back: phase sequencer with registered result beat
	i2cmbe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.phase_ticks (phase_ticks_q),
		.in_valid    (q_valid),
		.in_ready    (q_ready),
		.item        (q_item),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.result      (res)
	);

	assign m_tdata = {2'b00, res.ack_ok, res.rx_byte, res.done_res, res.busy_res,
		res.sda_level, res.sda_drive, res.scl_level};

endmodule

@@ tb/tb_i2c_master_byte_engine_top.sv @@
`timescale 1ns / 1ps

module tb_i2c_master_byte_engine_top;
	import i2cmbe_pkg::*;

	// Tracks the bus line state tick by tick. Every accepted input beat yields
	// one predicted output beat, kept in order until the DUT produces it.
	class i2c_line_scoreboard;
		logic [15:0] half_ticks;
		cmd_t        cmd;
		logic [4:0]  phase;
		logic [15:0] cnt;
		logic [7:0]  shreg;
		logic [7:0]  rx_last;
		logic        ack_seen;
		logic        scl;
		logic        sda_oe;
		logic        sda_out;
		result_t     line_q[$];
		int          errors;

		function new();
			half_ticks = PHASE_TICKS_RESET;
			cmd        = CMD_NONE;
			phase      = '0;
			cnt        = '0;
			shreg      = '0;
			rx_last    = '0;
			ack_seen   = 1'b0;
			scl        = 1'b1;
			sda_oe     = 1'b1;
			sda_out    = 1'b1;
			errors     = 0;
		endfunction

		function void set_half_ticks(logic [15:0] v);
			half_ticks = v;
		endfunction

		function bit busy();
			return cmd != CMD_NONE;
		endfunction

		function int pending();
			return line_q.size();
		endfunction

		function void advance_bus_tick(logic [2:0] act, logic [7:0] tx, logic ack_in,
		                               logic sda);
			result_t r;
			int      len;
			int      last;
			logic    samp;
			logic    done;
			logic    bitv;
			samp = 1'b0;
			done = 1'b0;
			if (cmd == CMD_NONE && act >= CMD_START && act <= CMD_READ) begin
				cmd   = cmd_t'(act);
				phase = '0;
				cnt   = '0;
				shreg = (cmd == CMD_WRITE) ? tx : 8'h00;
			end
			if (cmd != CMD_NONE) begin
				len  = (half_ticks == 16'd0) ? 1 : int'(half_ticks);
				last = (cmd == CMD_WRITE) ? int'(WRITE_PHASES) :
				       (cmd == CMD_READ)  ? int'(READ_PHASES)  : int'(BUS_PHASES);
				case (cmd)
				CMD_START: begin
					if (phase == 5'd0) begin
						scl     = 1'b1;
						sda_out = 1'b1;
					end else if (phase == 5'd1) begin
						sda_out = 1'b0;
					end else begin
						scl = 1'b0;
					end
				end
				CMD_STOP: begin
					if (phase == 5'd0) begin
						scl     = 1'b0;
						sda_out = 1'b0;
					end else if (phase == 5'd1) begin
						scl = 1'b1;
					end else begin
						sda_out = 1'b1;
					end
				end
				CMD_WRITE: begin
					if (phase < WR_ACK_FIRST) begin
						bitv = |(shreg & (8'h80 >> (phase / 5'd3)));
						case (phase % 5'd3)
						5'd0: begin
							scl = 1'b0;
						end
						5'd1: begin
							scl     = 1'b0;
							sda_out = bitv;
						end
						default: begin
							scl     = 1'b1;
							sda_out = bitv;
						end
						endcase
					end else begin
						sda_oe = 1'b0;
						scl    = (phase == WR_ACK_SAMPLE);
						samp   = (phase == WR_ACK_SAMPLE);
					end
				end
				CMD_READ: begin
					if (phase == 5'd0) begin
						sda_out = 1'b1;
						sda_oe  = 1'b0;
					end else if (phase <= RD_LAST_BIT) begin
						// odd phases low, even phases high and sampled
						scl  = ~phase[0];
						samp = ~phase[0];
					end else if (phase == RD_ACK_LOW) begin
						scl = 1'b0;
					end else if (phase == RD_ACK_DRIVE) begin
						sda_oe  = 1'b1;
						sda_out = ack_in;
					end else if (phase == RD_ACK_HIGH) begin
						scl = 1'b1;
					end else begin
						scl = 1'b0;
					end
				end
				default: ;
				endcase
				if (int'(cnt) + 1 >= len) begin
					if (samp) begin
						if (cmd == CMD_WRITE)
							ack_seen = ~sda;
						else
							shreg = {shreg[6:0], sda};
					end
					cnt   = '0;
					phase = phase + 5'd1;
					if (int'(phase) >= last) begin
						if (cmd == CMD_WRITE)
							sda_oe = 1'b1;
						if (cmd == CMD_READ)
							rx_last = shreg;
						cmd   = CMD_NONE;
						phase = '0;
						done  = 1'b1;
					end
				end else begin
					cnt = cnt + 16'd1;
				end
			end
			r.scl_level = scl;
			r.sda_drive = sda_oe;
			r.sda_level = sda_out;
			r.busy_res  = (cmd != CMD_NONE);
			r.done_res  = done;
			r.rx_byte   = rx_last;
			r.ack_ok    = ack_seen;
			line_q.push_back(r);
		endfunction

		function void check_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_line_beat(logic [15:0] d);
			result_t e;
			if (line_q.size() == 0) begin
				$error("output beat 0x%04h with no expected line state", d);
				errors++;
				return;
			end
			e = line_q.pop_front();
			check_field("scl_level", e.scl_level, d[0]);
			check_field("sda_drive", e.sda_drive, d[1]);
			check_field("sda_level", e.sda_level, d[2]);
			check_field("busy_res",  e.busy_res,  d[3]);
			check_field("done_res",  e.done_res,  d[4]);
			check_field("rx_byte",   e.rx_byte,   d[12:5]);
			check_field("ack_ok",    e.ack_ok,    d[13]);
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [15:0]          cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // tx_byte[7:0], ack_level[8], sda_in[9], zero pad
	logic [S_TUSER_W-1:0] s_tuser;   // action[2:0]
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;   // scl[0], sda_drive[1], sda_level[2], busy[3],
	                                 // done[4], rx_byte[12:5], ack_ok[13], zero pad

	i2c_line_scoreboard sb = new();

	// no_idle turns off all random gaps and stalls on both sides (long phases)
	bit no_idle   = 1'b0;
	int snd_calm  = 0;
	int rcv_calm  = 0;
	int ticks_sent = 0;

	i2c_master_byte_engine_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Gap before a beat: usually random, with occasional runs of
	// back-to-back beats so both busy and gapless stretches get covered.
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		return $urandom_range(0, 13);
	endfunction

	// sda source per tick: 0 and 1 force the line, anything else is random
	function automatic logic pick_sda(int mode);
		if (mode == 0)
			return 1'b0;
		if (mode == 1)
			return 1'b1;
		return 1'($urandom_range(0, 1));
	endfunction

	// One bus tick on the input stream. tvalid stays high across gapless beats;
	// it only drops when a gap is drawn, so it is never toggled within a step.
	task automatic send_tick(input logic [2:0] act, input logic [7:0] tx,
	                         input logic ack, input logic sda);
		int gap;
		gap = no_idle ? 0 : draw_gap(snd_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, sda, ack, tx};
		s_tuser  <= act;
		do @(posedge clk); while (!s_tready);
		sb.advance_bus_tick(act, tx, ack, sda);
		ticks_sent++;
	endtask

	// Issue a command, then keep ticking until the predicted sequence ends.
	// Ticks sent while busy carry random actions, all of which must be ignored.
	task automatic run_cmd(input logic [2:0] cmd, input logic [7:0] tx,
	                       input logic ack, input int sda_mode);
		send_tick(cmd, tx, ack, pick_sda(sda_mode));
		while (sb.busy())
			send_tick(3'($urandom_range(0, 7)), 8'($urandom), ack, pick_sda(sda_mode));
	endtask

	// Idle ticks: no-op and unknown action codes
	task automatic noise_ticks(input int n);
		logic [2:0] act;
		repeat (n) begin
			act = ($urandom_range(0, 3) == 0) ? CMD_NONE : 3'($urandom_range(5, 7));
			send_tick(act, 8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end
	endtask

	// Let the pipeline drain until every predicted beat has been seen.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// phase_ticks write, only ever issued with the sequencer idle
	task automatic set_half_ticks(input logic [15:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_half_ticks(v);
	endtask

	// Mostly well-formed transactions (start, 1..3 byte ops, stop) with random
	// content; the rest are lone commands and idle noise.
	task automatic random_traffic(input int n);
		int base;
		int nops;
		base = ticks_sent;
		while (ticks_sent - base < n) begin
			if ($urandom_range(0, 99) < 85) begin
				run_cmd(CMD_START, 8'($urandom), 1'($urandom_range(0, 1)), 2);
				nops = $urandom_range(1, 3);
				repeat (nops) begin
					if ($urandom_range(0, 1))
						run_cmd(CMD_WRITE, 8'($urandom), 1'($urandom_range(0, 1)), 2);
					else
						run_cmd(CMD_READ, 8'($urandom), 1'($urandom_range(0, 1)), 2);
				end
				run_cmd(CMD_STOP, 8'($urandom), 1'($urandom_range(0, 1)), 2);
			end else if ($urandom_range(0, 1)) begin
				run_cmd(3'($urandom_range(1, 4)), 8'($urandom), 1'($urandom_range(0, 1)), 2);
			end else begin
				noise_ticks($urandom_range(1, 5));
			end
			if ($urandom_range(0, 3) == 0)
				noise_ticks($urandom_range(1, 3));
		end
	endtask

	// Output side: random stalls per beat, plus two long hold-offs so the
	// queue fills and s_tready must drop while the sender keeps offering.
	initial begin
		int stall;
		int got;
		got      = 0;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = no_idle ? 0 : draw_gap(rcv_calm);
			if (!no_idle && (got == 400 || got == 700))
				stall = 150;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_line_beat(m_tdata);
			got++;
		end
	end

	// Watchdog, far above the slowest legal run with every gap and hold-off at its longest
	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int lens[4];
		lens      = '{16'd2, 16'd1, 16'd3, 16'd4};
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset phase length of 5
		run_cmd(CMD_START, 8'h00, 1'b0, 2);

		// directed, shortest phases
		set_half_ticks(16'd1);
		noise_ticks(1);
		send_tick(3'd5, 8'h00, 1'b0, 1'b0);
		send_tick(3'd6, 8'hFF, 1'b1, 1'b1);
		send_tick(3'd7, 8'h5A, 1'b1, 1'b0);
		send_tick(CMD_NONE, 8'hFF, 1'b1, 1'b1);
		run_cmd(CMD_START, 8'hFF, 1'b1, 1);
		run_cmd(CMD_WRITE, 8'h00, 1'b0, 0);   // slave acks
		run_cmd(CMD_WRITE, 8'hFF, 1'b1, 1);   // slave nacks
		run_cmd(CMD_WRITE, 8'hA5, 1'b0, 2);
		run_cmd(CMD_READ,  8'h00, 1'b0, 1);   // all-ones byte, master ack
		run_cmd(CMD_READ,  8'hFF, 1'b1, 0);   // all-zeros byte, master nack
		run_cmd(CMD_READ,  8'h3C, 1'b0, 2);
		run_cmd(CMD_STOP,  8'h00, 1'b0, 2);
		// lone stop and read with no start in front
		run_cmd(CMD_STOP,  8'h00, 1'b1, 2);
		run_cmd(CMD_READ,  8'h00, 1'b1, 2);

		// zero length behaves as one tick per phase
		set_half_ticks(16'd0);
		run_cmd(CMD_START, 8'h00, 1'b0, 2);
		run_cmd(CMD_WRITE, 8'h96, 1'b0, 2);
		run_cmd(CMD_READ,  8'h00, 1'b1, 2);
		run_cmd(CMD_STOP,  8'h00, 1'b0, 2);

		// random transactions across several phase lengths
		foreach (lens[i]) begin
			set_half_ticks(16'(lens[i]));
			random_traffic(150);
		end

		// longer phase: one start, no gaps on either side
		set_half_ticks(16'd20);
		no_idle = 1'b1;
		run_cmd(CMD_START, 8'h00, 1'b0, 2);

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
